// ===== design/serial_eeprom_command_engine_defines.svh =====
// Assertion macros shared by the checker of the serial EEPROM command engine.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef SERIAL_EEPROM_COMMAND_ENGINE_DEFINES_SVH
`define SERIAL_EEPROM_COMMAND_ENGINE_DEFINES_SVH

// Clocked property, ignored while reset is held.
`define SEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked while reset is held.
`define SEC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== design/seeprom_pkg.sv =====
// Types and constants of the serial EEPROM command engine.
// Depends on nothing; used by the top level.
package seeprom_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_CYCLES = 2'd2;
    localparam logic [19:0] BUSY_CYCLES_RESET = 20'd375000;

    // Command codes
    localparam logic [7:0] CMD_STATUS     = 8'h00;
    localparam logic [7:0] CMD_STATUS_ALT = 8'hff;
    localparam logic [7:0] CMD_READ       = 8'h04;
    localparam logic [7:0] CMD_WRITE      = 8'h05;

    // Response bytes
    localparam logic [7:0] SIZE_SMALL     = 8'h80;
    localparam logic [7:0] SIZE_LARGE     = 8'hc0;
    localparam logic [7:0] BUSY_FLAG      = 8'h80;
    localparam logic [7:0] READ_BUSY_BYTE = 8'hff;

    // Frame limits and addressing
    localparam logic [3:0] MAX_BYTES = 4'd8;
    localparam logic [3:0] HDR_BYTES = 4'd2;
    localparam int FULL_AW = 11;
    localparam logic [FULL_AW-1:0] MASK_SMALL = 11'h1ff;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        K_STATUS,
        K_READ,
        K_WRITE,
        K_REFUSE
    } t_kind;

endpackage

// ===== design/seeprom_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module seeprom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/serial_eeprom_command_engine.sv =====
// Serial EEPROM command engine: answers status, read and write frames.
// Depends on seeprom_pkg and seeprom_ram.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------
//  command   | i_start, o_busy       | i_op, i_command, i_block_address, i_send_len,
//            |                       | i_recv_len, i_write_data, i_tick_cycles
//  config    | i_cfg_we              | i_cfg_index, i_cfg_data
//  result    | o_strobe              | o_data_byte, o_frame_valid, o_last
//
// A frame's response bytes leave through the result register; a write to an idle
// device first stores its payload bytes (up to 8) one by one on the single RAM
// write port. Read data comes registered from the RAM, prefetched so bytes leave
// back to back. After reset a clearing pass writes zero to every entry with
// o_busy high; configuration writes are taken throughout. Results cannot stall.
module serial_eeprom_command_engine #(
    parameter int MEM_BYTES = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic                                  i_op,
    input  logic [7:0]                            i_command,
    input  logic [7:0]                            i_block_address,
    input  logic [3:0]                            i_send_len,
    input  logic [3:0]                            i_recv_len,
    input  logic [63:0]                           i_write_data,
    input  logic [31:0]                           i_tick_cycles,
    input  logic                                  i_cfg_we,
    input  logic [seeprom_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [seeprom_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                  o_strobe,
    output logic [7:0]                            o_data_byte,
    output logic                                  o_frame_valid,
    output logic                                  o_last
);
    import seeprom_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [FULL_AW:0] MEM_LIMIT = (FULL_AW + 1)'(MEM_BYTES);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MEM_BYTES - 1);

    // Byte address inside the device, wrapped to the configured size
    function automatic logic [FULL_AW-1:0] f_addr(input logic [7:0] blk,
                                                  input logic [2:0] off,
                                                  input logic       wide);
        logic [FULL_AW-1:0] a;
        a = {blk, off};
        return wide ? a : (a & MASK_SMALL);
    endfunction

    // Configuration registers
    logic        r_present;
    logic        r_large;
    logic [19:0] r_busy_cycles;

    // Control and item registers
    t_state      r_state, n_state;
    t_kind       r_kind, n_kind;
    logic [AW-1:0] r_clr, n_clr;
    logic [2:0]  r_idx, n_idx;
    logic [3:0]  r_n, n_n;
    logic [3:0]  r_wcnt, n_wcnt;
    logic [7:0]  r_block, n_block;
    logic        r_busy_snap, n_busy_snap;
    logic [63:0] r_wdata, n_wdata;
    logic [19:0] r_cd, n_cd;
    logic        r_rd_oor;

    // Result register
    logic        r_strobe, n_strobe;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_valid, n_out_valid;
    logic        r_out_last, n_out_last;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Decode helpers
    logic               accept;
    logic [3:0]         n_in;
    logic [3:0]         wdiff;
    logic [3:0]         wcnt_in;
    logic               cd_busy;
    logic               is_status, is_read, is_write;
    logic [FULL_AW-1:0] rd_full, wr_full;
    logic               rd_oor, wr_oor;
    logic               resp_last;

    seeprom_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes, accepted in any state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present     <= 1'b1;
            r_large       <= 1'b0;
            r_busy_cycles <= BUSY_CYCLES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRESENT:     r_present     <= i_cfg_data[0];
                CFG_LARGE:       r_large       <= i_cfg_data[0];
                CFG_BUSY_CYCLES: r_busy_cycles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame decode
    assign accept    = i_start && (r_state == S_IDLE);
    assign n_in      = (i_recv_len > MAX_BYTES) ? MAX_BYTES : i_recv_len;
    assign wdiff     = i_send_len - HDR_BYTES;
    assign wcnt_in   = (wdiff > MAX_BYTES) ? MAX_BYTES : wdiff;
    assign cd_busy   = (r_cd != 20'd0);
    assign is_status = r_present && (i_command inside {CMD_STATUS, CMD_STATUS_ALT});
    assign is_read   = r_present && (i_command == CMD_READ) && (i_send_len >= HDR_BYTES);
    assign is_write  = r_present && (i_command == CMD_WRITE) && (i_send_len >= HDR_BYTES)
                       && (n_in != 4'd0);

    // Addresses: read prefetches the next byte, write uses the current one
    assign rd_full   = (r_state == S_RESP) ? f_addr(r_block, r_idx + 3'd1, r_large)
                                           : f_addr(i_block_address, 3'd0, r_large);
    assign wr_full   = f_addr(r_block, r_idx, r_large);
    assign rd_oor    = {1'b0, rd_full} >= MEM_LIMIT;
    assign wr_oor    = {1'b0, wr_full} >= MEM_LIMIT;
    assign ram_raddr = rd_full[AW-1:0];
    assign resp_last = (({1'b0, r_idx} + 4'd1) == r_n);

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_n         = r_n;
        n_wcnt      = r_wcnt;
        n_block     = r_block;
        n_busy_snap = r_busy_snap;
        n_wdata     = r_wdata;
        n_cd        = r_cd;
        n_strobe    = 1'b0;
        n_out_byte  = r_out_byte;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = 8'd0;

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + AW'(1);
                if (r_clr == LAST_ENTRY) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept && i_op) begin
                    // Time tick: countdown saturates at zero
                    if ({12'd0, r_cd} <= i_tick_cycles) begin
                        n_cd = 20'd0;
                    end else begin
                        n_cd = r_cd - i_tick_cycles[19:0];
                    end
                end else if (accept) begin
                    n_block     = i_block_address;
                    n_busy_snap = cd_busy;
                    n_wdata     = i_write_data;
                    n_wcnt      = wcnt_in;
                    n_idx       = 3'd0;
                    n_n         = n_in;
                    if (is_status || is_read) begin
                        n_kind = is_status ? K_STATUS : K_READ;
                        if (n_in != 4'd0) begin
                            n_state = S_RESP;
                        end
                    end else if (is_write) begin
                        n_kind  = K_WRITE;
                        n_state = S_RESP;
                        if (!cd_busy) begin
                            n_cd = r_busy_cycles;
                            if (wcnt_in != 4'd0) begin
                                n_state = S_WRITE;
                            end
                        end
                    end else begin
                        n_kind  = K_REFUSE;
                        n_n     = 4'd1;
                        n_state = S_RESP;
                    end
                end
            end

            S_WRITE: begin
                // One payload byte per cycle; bytes past the device are dropped
                ram_we    = !wr_oor;
                ram_waddr = wr_full[AW-1:0];
                ram_wdata = r_wdata[7:0];
                n_wdata   = r_wdata >> 8;
                n_idx     = r_idx + 3'd1;
                if (({1'b0, r_idx} + 4'd1) == r_wcnt) begin
                    n_idx   = 3'd0;
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                n_strobe    = 1'b1;
                n_out_valid = (r_kind != K_REFUSE);
                n_out_last  = resp_last;
                case (r_kind)
                    K_STATUS: begin
                        if (r_idx == 3'd1) begin
                            n_out_byte = r_large ? SIZE_LARGE : SIZE_SMALL;
                        end else if (r_idx == 3'd2) begin
                            n_out_byte = r_busy_snap ? BUSY_FLAG : 8'd0;
                        end else begin
                            n_out_byte = 8'd0;
                        end
                    end
                    K_READ: begin
                        if (r_busy_snap) begin
                            n_out_byte = READ_BUSY_BYTE;
                        end else begin
                            n_out_byte = r_rd_oor ? 8'd0 : ram_rdata;
                        end
                    end
                    K_WRITE: begin
                        n_out_byte = (r_idx == 3'd0 && r_busy_snap) ? BUSY_FLAG : 8'd0;
                    end
                    default: begin
                        n_out_byte = 8'd0;
                    end
                endcase
                n_idx = r_idx + 3'd1;
                if (resp_last) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cd     <= 20'd0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cd     <= n_cd;
            r_strobe <= n_strobe;
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_idx       <= n_idx;
        r_n         <= n_n;
        r_wcnt      <= n_wcnt;
        r_block     <= n_block;
        r_busy_snap <= n_busy_snap;
        r_wdata     <= n_wdata;
        r_rd_oor    <= rd_oor;
        r_out_byte  <= n_out_byte;
        r_out_valid <= n_out_valid;
        r_out_last  <= n_out_last;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_data_byte   = r_out_byte;
    assign o_frame_valid = r_out_valid;
    assign o_last        = r_out_last;

endmodule

// ===== design/seeprom_checker.sv =====
// Port-level checker for the serial EEPROM command engine, bound to the top level.
// Depends on serial_eeprom_command_engine_defines.svh.
`include "serial_eeprom_command_engine_defines.svh"

module seeprom_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_strobe,
    input logic o_frame_valid,
    input logic o_last
);

    // No result leaves the block right after reset
    `SEC_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_strobe, "result strobe after reset")

    // A refused frame is a single, final result
    `SEC_ASSERT(a_refuse_last, (o_strobe && !o_frame_valid) |-> o_last,
                "refused frame result not marked last")

    // Bytes of one frame leave on consecutive cycles
    `SEC_ASSERT(a_frame_gapless, (o_strobe && !o_last) |=> o_strobe,
                "gap inside a response frame")

    // A transfer on the command channel is never followed at once by a result
    `SEC_ASSERT(a_accept_gap, (i_start && !o_busy) |=> !o_strobe,
                "result in the cycle after an accepted item")

endmodule

bind serial_eeprom_command_engine seeprom_checker u_seeprom_checker (.*);
